// ===== design/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int IDX_W     = 11;
    localparam int CH_W      = 8;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;
    localparam int CELL_W    = 16;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_TEXT_ATTR = 1'b0;

    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [CH_W-1:0] CH_NEWLINE       = 8'h0A;
    localparam logic [CH_W-1:0] CH_BACKSPACE     = 8'h08;
    localparam logic [CH_W-1:0] CH_SPACE         = 8'h20;
    localparam logic [CH_W-1:0] CH_LAST_PRINT    = 8'h7F;
    localparam logic [CH_W-1:0] ATTR_DEFAULT     = 8'h07;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCROLL,
        ST_POST,
        ST_RESP
    } tcw_state_t;

    typedef struct packed {
        logic take;
        logic use_latched;
        logic exec;
        logic scroll_rd0;
        logic sweep;
        logic clear;
        logic load_out;
    } tcw_cmd_t;

    typedef struct packed {
        logic is_read;
        logic is_nl;
        logic is_print;
        logic at_end;
        logic cnt_last;
        logic out_free;
    } tcw_status_t;

endpackage

// ===== design/tcw_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_if
// Request and response channels of the text console writer.
// ----------------------------------------------------------------------------
interface tcw_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [tcw_pkg::CH_W-1:0]    char_code;
    logic [tcw_pkg::IDX_W-1:0]   cell_index;

    modport source (output valid, output req_type, output char_code, output cell_index,
                    input ready);
    modport sink   (input valid, input req_type, input char_code, input cell_index,
                    output ready);
endinterface

interface tcw_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [tcw_pkg::ROW_OUT_W-1:0]   cursor_row;
    logic [tcw_pkg::COL_OUT_W-1:0]   cursor_col;
    logic [tcw_pkg::CH_W-1:0]        cell_char;
    logic [tcw_pkg::CH_W-1:0]        cell_attr;
    logic                            scrolled;

    modport source (output valid, output cursor_row, output cursor_col, output cell_char,
                    output cell_attr, output scrolled, input ready);
    modport sink   (input valid, input cursor_row, input cursor_col, input cell_char,
                    input cell_attr, input scrolled, output ready);
endinterface

// ===== design/text_console_writer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_top
// Character-cell text console: put/read requests on a cell memory with
// cursor tracking and one-line scroll.
//
//   Channel   Dir  Handshake               Payload
//   req_ch    in   valid/ready             req_type, char_code, cell_index
//   rsp_ch    out  valid/ready             cursor_row, cursor_col, cell_char,
//                                          cell_attr, scrolled
//   apb       in   psel/penable, pready=1  text_attribute at address 0
//
// A put or read transaction passes through dispatch and response load.
// A put that scrolls adds the scroll sweep and a post step; the sweep copies
// one cell per cycle through the cell memory's one read and one write port.
// After reset a clear pass writes every cell of the memory; req_ch
// is not ready meanwhile. A stalled response holds in the output register
// while the next request is accepted.
// ----------------------------------------------------------------------------
module text_console_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                             clk,
    input  logic                             rst_n,
    tcw_req_if.sink                          req_ch,
    tcw_rsp_if.source                        rsp_ch,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import tcw_pkg::*;

    tcw_cmd_t        cmd;
    tcw_status_t     status;
    logic [CH_W-1:0] attr;
    logic            ready;

    tcw_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .attr    (attr)
    );

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_ch.valid),
        .req_ready (ready),
        .status    (status),
        .cmd       (cmd)
    );

    tcw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .attr           (attr),
        .in_req_type    (req_ch.req_type),
        .in_char_code   (req_ch.char_code),
        .in_cell_index  (req_ch.cell_index),
        .out_valid      (rsp_ch.valid),
        .out_ready      (rsp_ch.ready),
        .out_cursor_row (rsp_ch.cursor_row),
        .out_cursor_col (rsp_ch.cursor_col),
        .out_cell_char  (rsp_ch.cell_char),
        .out_cell_attr  (rsp_ch.cell_attr),
        .out_scrolled   (rsp_ch.scrolled)
    );

    assign req_ch.ready = ready;

endmodule

// ===== design/tcw_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_regs
// APB-style configuration register: text attribute.
// ----------------------------------------------------------------------------
module tcw_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [tcw_pkg::CH_W-1:0]         attr
);
    import tcw_pkg::*;

    logic [CH_W-1:0] attr_reg;
    logic [CH_W-1:0] attr_next;
    logic            sel_attr;

    assign sel_attr = (paddr[APB_ADDR_W-1:2] == REG_TEXT_ATTR) && (paddr[1:0] == 2'b00)
                      || (paddr[APB_ADDR_W-1:2] == REG_TEXT_ATTR);

    always_comb
    begin
        attr_next = attr_reg;
        if (psel && penable && pwrite && sel_attr)
        begin
            attr_next = pwdata[CH_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_DEFAULT;
        end
        else
        begin
            attr_reg <= attr_next;
        end
    end

    assign prdata = sel_attr ? {{(APB_DATA_W-CH_W){1'b0}}, attr_reg} : '0;
    assign pready = 1'b1;
    assign attr   = attr_reg;

endmodule

// ===== design/tcw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: clear pass, request dispatch, scroll sweep, response load.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  tcw_pkg::tcw_status_t  status,
    output tcw_pkg::tcw_cmd_t     cmd
);
    import tcw_pkg::*;

    tcw_state_t state_reg;
    tcw_state_t state_next;
    logic       need_scroll;

    assign need_scroll = !status.is_read && (status.is_nl || status.is_print) && status.at_end;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.cnt_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = need_scroll ? ST_SCROLL : ST_RESP;
                end
            end
            ST_SCROLL:
            begin
                if (status.cnt_last)
                begin
                    state_next = ST_POST;
                end
            end
            ST_POST:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.take = 1'b1;
                    if (need_scroll)
                    begin
                        cmd.scroll_rd0 = 1'b1;
                    end
                    else
                    begin
                        cmd.exec = 1'b1;
                    end
                end
            end
            ST_SCROLL:
            begin
                cmd.sweep = 1'b1;
            end
            ST_POST:
            begin
                cmd.exec        = 1'b1;
                cmd.use_latched = 1'b1;
            end
            ST_RESP:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/tcw_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_dp
// Datapath: screen memory, cursor, sweep counter and response register.
// ----------------------------------------------------------------------------
module tcw_dp #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tcw_pkg::tcw_cmd_t                cmd,
    output tcw_pkg::tcw_status_t             status,
    input  logic [tcw_pkg::CH_W-1:0]         attr,
    input  logic                             in_req_type,
    input  logic [tcw_pkg::CH_W-1:0]         in_char_code,
    input  logic [tcw_pkg::IDX_W-1:0]        in_cell_index,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [tcw_pkg::ROW_OUT_W-1:0]    out_cursor_row,
    output logic [tcw_pkg::COL_OUT_W-1:0]    out_cursor_col,
    output logic [tcw_pkg::CH_W-1:0]         out_cell_char,
    output logic [tcw_pkg::CH_W-1:0]         out_cell_attr,
    output logic                             out_scrolled
);
    import tcw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int POS_W  = $clog2(CELLS + 1);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int CMP_W  = (POS_W > IDX_W) ? POS_W : IDX_W;

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rdata_reg;

    logic              wr_en;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              rd_en;
    logic [ADDR_W-1:0] raddr;

    logic [POS_W-1:0]  pos_reg,  pos_next;
    logic [ROW_W-1:0]  row_reg,  row_next;
    logic [COL_W-1:0]  col_reg,  col_next;
    logic [ADDR_W-1:0] cnt_reg,  cnt_next;
    logic [CH_W-1:0]   ch_reg,   ch_next;
    logic              req_reg,  req_next;
    logic              idx_ok_reg, idx_ok_next;
    logic              scr_reg,  scr_next;

    logic                 out_valid_reg, out_valid_next;
    logic [ROW_OUT_W-1:0] out_row_reg,   out_row_next;
    logic [COL_OUT_W-1:0] out_col_reg,   out_col_next;
    logic [CH_W-1:0]      out_char_reg,  out_char_next;
    logic [CH_W-1:0]      out_attr_reg,  out_attr_next;
    logic                 out_scr_reg,   out_scr_next;

    logic              in_idx_ok;
    logic              cur_req;
    logic [CH_W-1:0]   cur_ch;
    logic              cur_nl, cur_bs, cur_pr;
    logic              cnt_last;
    logic [POS_W-1:0]  sweep_rd;
    logic [POS_W-1:0]  pos_dec;

    assign in_idx_ok = CMP_W'(in_cell_index) < CMP_W'(CELLS);
    assign cnt_last  = (cnt_reg == ADDR_W'(CELLS - 1));
    assign sweep_rd  = POS_W'(cnt_reg) + POS_W'(COLUMNS + 1);
    assign pos_dec   = pos_reg - POS_W'(1);

    assign cur_req = cmd.use_latched ? req_reg : in_req_type;
    assign cur_ch  = cmd.use_latched ? ch_reg  : in_char_code;
    assign cur_nl  = (cur_req == REQ_PUT) && (cur_ch == CH_NEWLINE);
    assign cur_bs  = (cur_req == REQ_PUT) && (cur_ch == CH_BACKSPACE);
    assign cur_pr  = (cur_req == REQ_PUT) && (cur_ch >= CH_SPACE) && (cur_ch <= CH_LAST_PRINT);

    always_comb
    begin
        status.is_read  = (in_req_type == REQ_READ);
        status.is_nl    = (in_char_code == CH_NEWLINE);
        status.is_print = (in_char_code >= CH_SPACE) && (in_char_code <= CH_LAST_PRINT);
        status.at_end   = (row_reg == ROW_W'(ROWS));
        status.cnt_last = cnt_last;
        status.out_free = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        pos_next    = pos_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        cnt_next    = cnt_reg;
        ch_next     = ch_reg;
        req_next    = req_reg;
        idx_ok_next = idx_ok_reg;
        scr_next    = scr_reg;
        wr_en       = 1'b0;
        waddr       = '0;
        wdata       = '0;
        rd_en       = 1'b0;
        raddr       = '0;

        if (cmd.take)
        begin
            ch_next     = in_char_code;
            req_next    = in_req_type;
            idx_ok_next = in_idx_ok;
            scr_next    = 1'b0;
        end

        if (cmd.scroll_rd0)
        begin
            rd_en    = 1'b1;
            raddr    = ADDR_W'(COLUMNS);
            scr_next = 1'b1;
        end

        if (cmd.exec)
        begin
            priority if (cur_req == REQ_READ)
            begin
                rd_en = in_idx_ok;
                raddr = ADDR_W'(in_cell_index);
            end
            else if (cur_nl)
            begin
                pos_next = pos_reg - POS_W'(col_reg) + POS_W'(COLUMNS);
                row_next = row_reg + ROW_W'(1);
                col_next = '0;
            end
            else if (cur_bs)
            begin
                if (pos_reg != '0)
                begin
                    pos_next = pos_dec;
                    wr_en    = 1'b1;
                    waddr    = pos_dec[ADDR_W-1:0];
                    wdata    = {attr, CH_SPACE};
                    if (col_reg == '0)
                    begin
                        row_next = row_reg - ROW_W'(1);
                        col_next = COL_W'(COLUMNS - 1);
                    end
                    else
                    begin
                        col_next = col_reg - COL_W'(1);
                    end
                end
            end
            else if (cur_pr)
            begin
                wr_en    = 1'b1;
                waddr    = pos_reg[ADDR_W-1:0];
                wdata    = {attr, cur_ch};
                pos_next = pos_reg + POS_W'(1);
                if (col_reg == COL_W'(COLUMNS - 1))
                begin
                    row_next = row_reg + ROW_W'(1);
                    col_next = '0;
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            else
            begin
                pos_next = pos_reg;
            end
        end

        if (cmd.clear)
        begin
            wr_en    = 1'b1;
            waddr    = cnt_reg;
            wdata    = {ATTR_DEFAULT, CH_SPACE};
            cnt_next = cnt_last ? '0 : cnt_reg + ADDR_W'(1);
        end

        // scroll: cell i takes cell i+COLUMNS, last row blanked
        if (cmd.sweep)
        begin
            wr_en = 1'b1;
            waddr = cnt_reg;
            if (POS_W'(cnt_reg) < POS_W'(CELLS - COLUMNS))
            begin
                wdata = rdata_reg;
            end
            else
            begin
                wdata = {attr, CH_SPACE};
            end
            if (sweep_rd < POS_W'(CELLS))
            begin
                rd_en = 1'b1;
                raddr = sweep_rd[ADDR_W-1:0];
            end
            if (cnt_last)
            begin
                cnt_next = '0;
                pos_next = POS_W'(CELLS - COLUMNS);
                row_next = ROW_W'(ROWS - 1);
                col_next = '0;
            end
            else
            begin
                cnt_next = cnt_reg + ADDR_W'(1);
            end
        end
    end

    always_comb
    begin
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_char_next  = out_char_reg;
        out_attr_next  = out_attr_reg;
        out_scr_next   = out_scr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            out_row_next   = ROW_OUT_W'(row_reg);
            out_col_next   = COL_OUT_W'(col_reg);
            out_scr_next   = scr_reg;
            if ((req_reg == REQ_READ) && idx_ok_reg)
            begin
                out_char_next = rdata_reg[CH_W-1:0];
                out_attr_next = rdata_reg[CELL_W-1:CH_W];
            end
            else
            begin
                out_char_next = '0;
                out_attr_next = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg       <= ch_next;
        req_reg      <= req_next;
        idx_ok_reg   <= idx_ok_next;
        scr_reg      <= scr_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_char_reg <= out_char_next;
        out_attr_reg <= out_attr_next;
        out_scr_reg  <= out_scr_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_cursor_row = out_row_reg;
    assign out_cursor_col = out_col_reg;
    assign out_cell_char  = out_char_reg;
    assign out_cell_attr  = out_attr_reg;
    assign out_scrolled   = out_scr_reg;

endmodule

// ===== design/tcw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_ready,
    input logic                             rsp_valid,
    input logic                             rsp_ready,
    input logic [tcw_pkg::ROW_OUT_W-1:0]    rsp_cursor_row,
    input logic [tcw_pkg::COL_OUT_W-1:0]    rsp_cursor_col,
    input logic [tcw_pkg::CH_W-1:0]         rsp_cell_char,
    input logic [tcw_pkg::CH_W-1:0]         rsp_cell_attr,
    input logic                             rsp_scrolled
);
    import tcw_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_row)
            && $stable(rsp_cursor_col) && $stable(rsp_cell_char)
            && $stable(rsp_cell_attr) && $stable(rsp_scrolled))
        else $error("response changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while previous transaction in flight");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (int'(rsp_cursor_col) < COLUMNS))
        else $error("cursor column out of range");

    a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_scrolled |->
            ((rsp_cursor_row == ROW_OUT_W'(ROWS)) && (rsp_cursor_col == '0))
            || ((rsp_cursor_row == ROW_OUT_W'(ROWS - 1)) && (rsp_cursor_col == COL_OUT_W'(1))))
        else $error("cursor not on last lines after scroll");

    a_scroll_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_scrolled |-> (rsp_cell_char == '0) && (rsp_cell_attr == '0))
        else $error("scrolling put returned cell data");

endmodule

bind text_console_writer_top tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req_ch.valid),
    .req_ready      (req_ch.ready),
    .rsp_valid      (rsp_ch.valid),
    .rsp_ready      (rsp_ch.ready),
    .rsp_cursor_row (rsp_ch.cursor_row),
    .rsp_cursor_col (rsp_ch.cursor_col),
    .rsp_cell_char  (rsp_ch.cell_char),
    .rsp_cell_attr  (rsp_ch.cell_attr),
    .rsp_scrolled   (rsp_ch.scrolled)
);
